// File: sv/bed_pkg.sv
// ----------------------------------------------------------------------------
// bed_pkg: shared types and constants for the backslash escape decoder
// Character codes, escape values, decoder phases and the result beat format.
// ----------------------------------------------------------------------------
`default_nettype none

package bed_pkg;

  localparam logic [7:0] CH_BSL   = 8'h5C;  // '\'
  localparam logic [7:0] CH_LOW_C = 8'h63;  // 'c'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_UP_M  = 8'h4D;  // 'M'
  localparam logic [7:0] CH_CARET = 8'h5E;  // '^'
  localparam logic [7:0] CH_DASH  = 8'h2D;  // '-'
  localparam logic [7:0] CH_QUERY = 8'h3F;  // '?'
  localparam logic [7:0] CH_LOW_X = 8'h78;  // 'x'

  localparam logic [7:0] META_BIT_VAL = 8'h80;  // 0200
  localparam logic [7:0] DEL_VAL      = 8'h7F;  // 0177
  localparam logic [4:0] CTRL_MASK    = 5'h1F;  // 037
  localparam logic [7:0] ESC_VAL      = 8'h1B;  // 033

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_HALT = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;

  localparam logic MODE_ARG = 1'b0;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_BSL   = 3'd1,
    PH_OCT   = 3'd2,
    PH_HEX   = 3'd3,
    PH_M     = 3'd4,
    PH_MDASH = 3'd5,
    PH_CARET = 3'd6
  } phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic       bad;
    logic       last;
  } result_t;

  // up to two results per input beat, r1 only ever valid with r0
  typedef struct packed {
    logic    r0_valid;
    logic    r1_valid;
    result_t r0;
    result_t r1;
  } step_out_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] val;
  } hex_digit_t;

  function automatic hex_digit_t hex_digit(input logic [7:0] c);
    hex_digit_t h;
    h.hit = 1'b1;
    h.val = c[3:0];
    if (c >= 8'h30 && c <= 8'h39) begin
      h.val = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      h.val = c[3:0] + 4'd9;
    end else begin
      h.hit = 1'b0;
    end
    return h;
  endfunction

  // {hit, value} for the named C escapes
  function automatic logic [8:0] named_escape(input logic [7:0] c);
    logic [8:0] r;
    unique case (c)
      8'h5C:        r = {1'b1, 8'h5C};
      8'h27:        r = {1'b1, 8'h27};
      8'h22:        r = {1'b1, 8'h22};
      8'h61:        r = {1'b1, 8'h07};
      8'h62:        r = {1'b1, 8'h08};
      8'h65, 8'h45: r = {1'b1, ESC_VAL};
      8'h66:        r = {1'b1, 8'h0C};
      8'h6E:        r = {1'b1, 8'h0A};
      8'h72:        r = {1'b1, 8'h0D};
      8'h74:        r = {1'b1, 8'h09};
      8'h76:        r = {1'b1, 8'h0B};
      default:      r = {1'b0, c};
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: sv/bed_decoder.sv
// ----------------------------------------------------------------------------
// bed_decoder: escape state and single-pass step logic
// Holds the escape state and turns one registered input beat into up to two
// result beats, including the end-of-string flush and end marker.
// ----------------------------------------------------------------------------
`default_nettype none

module bed_decoder
  import bed_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       fire,
  input  wire logic [7:0] c,
  input  wire logic       eos,
  input  wire logic       escape_mode,
  output step_out_t       step
);

  phase_t     phase, phase_next;
  logic [8:0] accum, accum_next;
  logic [1:0] digits_seen, digits_next;
  logic       meta_bit, meta_next;
  logic       halted, halted_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      accum       <= '0;
      digits_seen <= '0;
      meta_bit    <= 1'b0;
      halted      <= 1'b0;
    end else if (fire) begin
      phase       <= phase_next;
      accum       <= accum_next;
      digits_seen <= digits_next;
      meta_bit    <= meta_next;
      halted      <= halted_next;
    end
  end

  always_comb begin
    result_t    a_r, b_r, f_r, m_r;
    logic       a_v, b_v, f_v, m_v, fresh, is_oct, mode_arg;
    hex_digit_t hx;
    logic [8:0] ne, acc_oct, acc_hex;

    phase_next  = phase;
    accum_next  = accum;
    digits_next = digits_seen;
    meta_next   = meta_bit;
    halted_next = halted;
    a_v = 1'b0; b_v = 1'b0; f_v = 1'b0; fresh = 1'b0;
    a_r = '0; b_r = '0; f_r = '0; m_r = '0;
    hx       = hex_digit(c);
    ne       = named_escape(c);
    is_oct   = (c >= 8'h30) && (c <= 8'h37);
    mode_arg = (escape_mode == MODE_ARG);
    acc_oct  = {accum[5:0], c[2:0]};
    acc_hex  = {accum[4:0], hx.val};

    if (!halted) begin
      unique case (phase)
        PH_BSL: begin
          phase_next = PH_IDLE; accum_next = '0; digits_next = '0; meta_next = 1'b0;
          if (mode_arg && c == CH_LOW_C) begin
            a_v = 1'b1;
            a_r = '{data: 8'h00, kind: KIND_HALT, bad: 1'b0, last: 1'b0};
            halted_next = 1'b1;
          end else if (mode_arg && c == CH_ZERO) begin
            phase_next = PH_OCT;
          end else if (mode_arg && c == CH_UP_M) begin
            phase_next = PH_M;
          end else if (mode_arg && c == CH_CARET) begin
            phase_next = PH_CARET;
          end else if (is_oct) begin
            phase_next  = PH_OCT;
            accum_next  = {6'd0, c[2:0]};
            digits_next = 2'd1;
          end else if (c == CH_LOW_X) begin
            phase_next = PH_HEX;
          end else begin
            a_v = 1'b1;
            a_r = '{data: ne[7:0], kind: KIND_DATA, bad: !ne[8], last: 1'b0};
          end
        end
        PH_OCT: begin
          if (is_oct && digits_seen != 2'd3) begin
            accum_next  = acc_oct;
            digits_next = digits_seen + 2'd1;
            if (digits_seen == 2'd2) begin
              a_v = 1'b1;
              a_r = '{data: acc_oct[7:0], kind: KIND_DATA, bad: 1'b0, last: 1'b0};
              phase_next = PH_IDLE; accum_next = '0; digits_next = '0; meta_next = 1'b0;
            end
          end else begin
            a_v = 1'b1;
            a_r = '{data: accum[7:0], kind: KIND_DATA, bad: 1'b0, last: 1'b0};
            phase_next = PH_IDLE; accum_next = '0; digits_next = '0; meta_next = 1'b0;
            fresh = 1'b1;
          end
        end
        PH_HEX: begin
          if (hx.hit && digits_seen < 2'd2) begin
            accum_next  = acc_hex;
            digits_next = digits_seen + 2'd1;
            if (digits_seen == 2'd1) begin
              a_v = 1'b1;
              a_r = '{data: acc_hex[7:0], kind: KIND_DATA, bad: 1'b0, last: 1'b0};
              phase_next = PH_IDLE; accum_next = '0; digits_next = '0; meta_next = 1'b0;
            end
          end else begin
            a_v = 1'b1;
            a_r = '{data: accum[7:0], kind: KIND_DATA, bad: (digits_seen == 2'd0),
                    last: 1'b0};
            phase_next = PH_IDLE; accum_next = '0; digits_next = '0; meta_next = 1'b0;
            fresh = 1'b1;
          end
        end
        PH_M: begin
          if (c == CH_DASH) begin
            phase_next = PH_MDASH;
          end else if (c == CH_CARET) begin
            phase_next = PH_CARET;
            meta_next  = 1'b1;
          end else begin
            a_v = 1'b1;
            a_r = '{data: CH_UP_M, kind: KIND_DATA, bad: 1'b1, last: 1'b0};
            phase_next = PH_IDLE; accum_next = '0; digits_next = '0; meta_next = 1'b0;
            fresh = 1'b1;
          end
        end
        PH_MDASH: begin
          a_v = 1'b1;
          a_r = '{data: META_BIT_VAL | c, kind: KIND_DATA, bad: 1'b0, last: 1'b0};
          phase_next = PH_IDLE; accum_next = '0; digits_next = '0; meta_next = 1'b0;
        end
        PH_CARET: begin
          a_v = 1'b1;
          a_r.kind = KIND_DATA;
          a_r.data = (meta_bit ? META_BIT_VAL : 8'h00) |
                     ((c == CH_QUERY) ? DEL_VAL : {3'd0, c[4:0] & CTRL_MASK});
          phase_next = PH_IDLE; accum_next = '0; digits_next = '0; meta_next = 1'b0;
        end
        default: begin
          phase_next = PH_IDLE; accum_next = '0; digits_next = '0; meta_next = 1'b0;
          fresh = 1'b1;
        end
      endcase

      // byte that ended an escape (or a plain byte) handled as new input
      if (fresh) begin
        if (c == CH_BSL) begin
          phase_next = PH_BSL;
        end else begin
          b_v = 1'b1;
          b_r = '{data: c, kind: KIND_DATA, bad: 1'b0, last: 1'b0};
        end
      end
    end

    // end-of-string flush of whatever escape is still open
    if (eos && !halted_next) begin
      f_r.kind = KIND_DATA;
      unique case (phase_next)
        PH_BSL:   begin f_v = 1'b1; f_r.data = CH_BSL;  f_r.bad = 1'b1; end
        PH_OCT:   begin f_v = 1'b1; f_r.data = accum_next[7:0]; end
        PH_HEX:   begin
          f_v = 1'b1;
          f_r.data = accum_next[7:0];
          f_r.bad  = (digits_next == 2'd0);
        end
        PH_M:     begin f_v = 1'b1; f_r.data = CH_UP_M; f_r.bad = 1'b1; end
        PH_MDASH: begin f_v = 1'b1; f_r.data = META_BIT_VAL; end
        PH_CARET: begin f_v = 1'b1; f_r.data = meta_next ? META_BIT_VAL : 8'h00; end
        default:  f_v = 1'b0;
      endcase
    end

    if (eos) begin
      phase_next = PH_IDLE; accum_next = '0; digits_next = '0; meta_next = 1'b0;
      halted_next = 1'b0;
    end

    m_v = eos && !a_v && !b_v && !f_v;
    m_r = '{data: 8'h00, kind: KIND_END, bad: 1'b0, last: 1'b0};

    // pack the first two results in order
    step = '0;
    step.r0_valid = a_v || b_v || f_v || m_v;
    if (a_v) begin
      step.r0       = a_r;
      step.r1       = b_v ? b_r : f_r;
      step.r1_valid = b_v || f_v;
    end else if (b_v) begin
      step.r0       = b_r;
      step.r1       = f_r;
      step.r1_valid = f_v;
    end else if (f_v) begin
      step.r0 = f_r;
    end else begin
      step.r0 = m_r;
    end
    if (eos) begin
      if (step.r1_valid) begin
        step.r1.last = 1'b1;
      end else begin
        step.r0.last = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/bed_out_buf.sv
// ----------------------------------------------------------------------------
// bed_out_buf: two-slot result buffer
// Slot a drives the output port; slot b holds the second result of a beat
// that produced two. New results are taken only while slot b is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module bed_out_buf
  import bed_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire step_out_t step,
  output logic           can_take,
  output logic           out_valid,
  input  wire logic      out_ready,
  output result_t        head
);

  logic    a_valid, b_valid;
  result_t a_res, b_res;
  logic    pop;

  assign pop       = a_valid && out_ready;
  assign can_take  = !b_valid && (!a_valid || out_ready);
  assign out_valid = a_valid;
  assign head      = a_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else if (b_valid) begin
      if (pop) begin
        a_valid <= 1'b1;
        b_valid <= 1'b0;
      end
    end else if (push && step.r0_valid) begin
      a_valid <= 1'b1;
      b_valid <= step.r1_valid;
    end else if (pop) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_valid) begin
      if (pop) begin
        a_res <= b_res;
      end
    end else if (push && step.r0_valid) begin
      a_res <= step.r0;
      b_res <= step.r1;
    end
  end

endmodule

`default_nettype wire

// File: sv/backslash_escape_decoder_core.sv
// ----------------------------------------------------------------------------
// backslash_escape_decoder_core: backslash escape decoder, one byte a cycle unless stalled
// Input register, single-pass escape decoder and a two-slot result buffer.
// ----------------------------------------------------------------------------
//  channel   signals                                        direction
//  in        in_valid/in_ready, in_byte, end_of_string      sink
//  out       out_valid/out_ready, out_byte, result_kind,    source
//            bad_escape, last_result
//  cfg       cfg_we, cfg_wdata (escape_mode)                write only
//
//  One input beat per cycle unless stalled; a byte is held in the input register,
//  and its first result in slot a of the result buffer. A byte giving two results
//  holds the input side while the second result leaves through the single output slot.
//  rst (synchronous) clears escape state, halt flag, buffers and escape_mode.
//  Stalls on out_ready back up through the result buffer to in_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module backslash_escape_decoder_core
  import bed_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic       cfg_wdata,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       end_of_string,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic [1:0]      result_kind,
  output logic            bad_escape,
  output logic            last_result
);

  logic       escape_mode;
  logic       iv;
  logic [7:0] ibyte;
  logic       ieos;
  logic       can_take;
  logic       fire;
  step_out_t  step;
  result_t    head;

  assign fire     = iv && can_take;
  assign in_ready = !iv || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_mode <= 1'b0;
    end else if (cfg_we) begin
      escape_mode <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
    end else if (in_valid && in_ready) begin
      iv <= 1'b1;
    end else if (fire) begin
      iv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ibyte <= in_byte;
      ieos  <= end_of_string;
    end
  end

  bed_decoder u_decoder (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .c           (ibyte),
    .eos         (ieos),
    .escape_mode (escape_mode),
    .step        (step)
  );

  bed_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (fire),
    .step      (step),
    .can_take  (can_take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign out_byte    = head.data;
  assign result_kind = head.kind;
  assign bad_escape  = head.bad;
  assign last_result = head.last;

endmodule

`default_nettype wire
